// ===== design/pngse_pkg.sv =====
// shared types, constants and byte helpers for the png stored-deflate encoder
// used by pngse_front, pngse_queue, pngse_back and the top level
package pngse_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [14:0] DIM_MAX   = 15'd16384;

    // config register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // chunk type selectors for type_byte
    localparam logic [1:0] CHUNK_IHDR = 2'd0;
    localparam logic [1:0] CHUNK_IDAT = 2'd1;
    localparam logic [1:0] CHUNK_IEND = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIG,
        ST_IHDR_LEN,
        ST_IHDR_TYPE,
        ST_IHDR_DATA,
        ST_IHDR_CRC,
        ST_IDAT_LEN,
        ST_IDAT_TYPE,
        ST_ZHDR,
        ST_BLK,
        ST_RAW,
        ST_ADLER,
        ST_IDAT_CRC,
        ST_IEND_LEN,
        ST_IEND_TYPE,
        ST_IEND_CRC
    } t_step;

    // one classified input beat
    typedef struct packed {
        logic       start;
        logic       filter;
        logic       last;
        logic [7:0] px;
    } t_entry;

    // image geometry handed from front to back
    typedef struct packed {
        logic [14:0] lat_w;
        logic [14:0] lat_h;
        logic [30:0] raw;
        logic [31:0] idat_len;
        logic        ready;
    } t_dims;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] sig_byte(input logic [3:0] i);
        logic [7:0] v;
        case (i)
            4'd0: v = 8'h89;
            4'd1: v = 8'h50;
            4'd2: v = 8'h4E;
            4'd3: v = 8'h47;
            4'd4: v = 8'h0D;
            4'd5: v = 8'h0A;
            4'd6: v = 8'h1A;
            4'd7: v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // chunk type letters
    function automatic logic [7:0] type_byte(input logic [1:0] sel, input logic [3:0] i);
        logic [31:0] t;
        case (sel)
            CHUNK_IHDR: t = 32'h49484452;
            CHUNK_IDAT: t = 32'h49444154;
            default:    t = 32'h49454E44;
        endcase
        return t[31 - 8 * i[1:0] -: 8];
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [3:0] i);
        return v[31 - 8 * i[1:0] -: 8];
    endfunction

    function automatic logic [14:0] clamp_dim(input logic [14:0] v);
        logic [14:0] r;
        if (v == 15'd0) begin
            r = 15'd1;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/pngse_front.sv =====
// front end: accepts pixel beats, tags row starts, image start and image end,
// and works out the idat geometry with a reciprocal multiply; uses pngse_pkg
module pngse_front #(
    parameter int MAX_STORED_BLOCK = 65535
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [14:0]           i_image_width,
    input  logic [14:0]           i_image_height,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_pixel_byte,
    input  logic                  i_queue_full,
    input  logic                  i_hdr_done,
    output logic                  o_in_stall,
    output logic                  o_push,
    output pngse_pkg::t_entry     o_entry,
    output pngse_pkg::t_dims      o_dims
);

    localparam int CAP = (MAX_STORED_BLOCK < 2) ? 2 : MAX_STORED_BLOCK;
    localparam logic [30:0] CAP31 = 31'(CAP);
    // floor(x / CAP) == (x * RECIP) >> SHIFT for every 31-bit x
    localparam int SHIFT = 31 + $clog2(CAP);
    localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(CAP) - 64'd1) / 64'(CAP);
    localparam logic [31:0] RECIP = RECIP64[31:0];
    localparam logic [5:0] C_RAW = 6'd0;
    localparam logic [5:0] C_MUL = 6'd1;
    localparam logic [5:0] C_REM = 6'd2;
    localparam logic [5:0] C_LEN = 6'd3;

    logic        r_in_image;
    logic        r_hdr_pending;
    logic [16:0] r_row_b;
    logic [13:0] r_row_i;
    logic [14:0] r_lat_w;
    logic [14:0] r_lat_h;
    logic        r_busy;
    logic        r_ready;
    logic [5:0]  r_cnt;
    logic [30:0] r_raw;
    logic [30:0] r_q;
    logic [30:0] r_nblk;
    logic [31:0] r_idat_len;

    logic        accept;
    logic        is_start;
    logic [14:0] lw;
    logic [14:0] lh;
    logic [16:0] rb;
    logic [13:0] ri;
    logic [16:0] rb_next;
    logic        rowend;
    logic        last;
    logic [62:0] prod;
    logic [30:0] qd;

    assign o_in_stall = i_queue_full || (!r_in_image && r_hdr_pending);
    assign accept = i_in_valid && !o_in_stall;
    assign o_push = accept;

    always_comb begin
        is_start = !r_in_image;
        lw = is_start ? pngse_pkg::clamp_dim(i_image_width) : r_lat_w;
        lh = is_start ? pngse_pkg::clamp_dim(i_image_height) : r_lat_h;
        rb = is_start ? 17'd0 : r_row_b;
        ri = is_start ? 14'd0 : r_row_i;
        rb_next = rb + 17'd1;
        rowend = (rb_next == {lw, 2'b00});
        last = rowend && (ri == 14'(lh - 15'd1));
        o_entry.start = is_start;
        o_entry.filter = (rb == 17'd0);
        o_entry.last = last;
        o_entry.px = i_pixel_byte;
    end

    // block count: quotient by reciprocal, plus one for a partial last block
    assign prod = r_raw * RECIP;
    assign qd = r_q * CAP31;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_image <= 1'b0;
            r_hdr_pending <= 1'b0;
            r_busy <= 1'b0;
            r_ready <= 1'b0;
            r_cnt <= 6'd0;
            r_row_b <= 17'd0;
            r_row_i <= 14'd0;
            r_lat_w <= 15'd1;
            r_lat_h <= 15'd1;
        end else begin
            if (i_hdr_done) begin
                r_hdr_pending <= 1'b0;
            end
            if (accept) begin
                if (is_start) begin
                    r_lat_w <= lw;
                    r_lat_h <= lh;
                    r_hdr_pending <= 1'b1;
                    r_busy <= 1'b1;
                    r_ready <= 1'b0;
                    r_cnt <= C_RAW;
                end
                r_in_image <= !last;
                r_row_b <= rowend ? 17'd0 : rb_next;
                r_row_i <= rowend ? ri + 14'd1 : ri;
            end
            if (r_busy && !(accept && is_start)) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == C_LEN) begin
                    r_busy <= 1'b0;
                    r_ready <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_cnt == C_RAW) begin
                r_raw <= 31'(r_lat_h) * 31'({r_lat_w, 2'b00} + 17'd1);
            end else if (r_cnt == C_MUL) begin
                r_q <= 31'(prod >> SHIFT);
            end else if (r_cnt == C_REM) begin
                r_nblk <= r_q + {30'd0, (qd != r_raw)};
            end else begin
                r_idat_len <= 32'd6 + {1'b0, r_raw} + {r_nblk[29:0], 2'b00}
                    + {1'b0, r_nblk};
            end
        end
    end

    assign o_dims.lat_w = r_lat_w;
    assign o_dims.lat_h = r_lat_h;
    assign o_dims.raw = r_raw;
    assign o_dims.idat_len = r_idat_len;
    assign o_dims.ready = r_ready;

endmodule

// ===== design/pngse_queue.sv =====
// short queue of classified beats between front and back
// uses pngse_pkg for the entry type
module pngse_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pngse_pkg::t_entry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output pngse_pkg::t_entry o_head
);

    pngse_pkg::t_entry r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;
    logic       pop_ok;

    assign o_full = (r_count == 3'd4);
    assign o_valid = (r_count != 3'd0);
    assign o_head = r_mem[r_rd];
    assign pop_ok = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 2'd0;
            r_rd <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= r_count + {2'd0, i_push} - {2'd0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== design/pngse_back.sv =====
// back end: byte sequencer that writes png framing, zlib stored blocks,
// crc-32 and adler-32 into an output register; uses pngse_pkg
module pngse_back #(
    parameter int MAX_STORED_BLOCK = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  pngse_pkg::t_entry i_head,
    input  pngse_pkg::t_dims  i_dims,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_hdr_done,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_file_last
);

    localparam int CAP = (MAX_STORED_BLOCK < 2) ? 2 : MAX_STORED_BLOCK;
    localparam logic [15:0] CAP16 = 16'(CAP);

    pngse_pkg::t_step r_step;
    pngse_pkg::t_step n_step;
    pngse_pkg::t_step base;
    pngse_pkg::t_step cur;
    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic        r_sel;
    logic        n_sel;
    logic        sel;
    logic [3:0]  last_idx;
    logic        at_end;
    logic        have;
    logic        slot_free;
    logic        emit;
    logic        done;

    logic [31:0] r_crc;
    logic [15:0] r_adler_a;
    logic [15:0] r_adler_b;
    logic [15:0] r_blk_left;
    logic [30:0] r_raw_left;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_run_last;
    logic        r_file_last;

    logic [7:0]  byte_val;
    logic        crc_on;
    logic        crc_init;
    logic [31:0] crc_next;
    logic [15:0] size;
    logic [16:0] a_sum;
    logic [16:0] a_new;
    logic [16:0] b_sum;
    logic [16:0] b_new;

    assign slot_free = !r_out_valid || !i_out_stall;

    // step in force this cycle, a new entry dispatches straight from idle
    always_comb begin
        if (r_step == pngse_pkg::ST_IDLE) begin
            base = !i_head_valid ? pngse_pkg::ST_IDLE
                 : (i_head.start ? pngse_pkg::ST_SIG : pngse_pkg::ST_RAW);
            sel = !i_head.filter;
        end else begin
            base = r_step;
            sel = r_sel;
        end
        cur = (base == pngse_pkg::ST_RAW && r_blk_left == 16'd0) ? pngse_pkg::ST_BLK : base;
        have = (cur != pngse_pkg::ST_IDLE)
            && !(cur == pngse_pkg::ST_IDAT_LEN && !i_dims.ready);
        emit = have && slot_free;
        size = (r_raw_left < 31'(CAP)) ? r_raw_left[15:0] : CAP16;
    end

    // next step
    always_comb begin
        case (cur)
            pngse_pkg::ST_SIG:       last_idx = 4'd7;
            pngse_pkg::ST_IHDR_DATA: last_idx = 4'd12;
            pngse_pkg::ST_ZHDR:      last_idx = 4'd1;
            pngse_pkg::ST_BLK:       last_idx = 4'd4;
            pngse_pkg::ST_RAW:       last_idx = 4'd0;
            default:                 last_idx = 4'd3;
        endcase
        at_end = (r_idx == last_idx);
        n_step = r_step;
        n_idx = r_idx;
        n_sel = r_sel;
        if (emit) begin
            n_sel = sel;
            if (!at_end) begin
                n_step = cur;
                n_idx = r_idx + 4'd1;
            end else begin
                n_idx = 4'd0;
                case (cur)
                    pngse_pkg::ST_SIG:       n_step = pngse_pkg::ST_IHDR_LEN;
                    pngse_pkg::ST_IHDR_LEN:  n_step = pngse_pkg::ST_IHDR_TYPE;
                    pngse_pkg::ST_IHDR_TYPE: n_step = pngse_pkg::ST_IHDR_DATA;
                    pngse_pkg::ST_IHDR_DATA: n_step = pngse_pkg::ST_IHDR_CRC;
                    pngse_pkg::ST_IHDR_CRC:  n_step = pngse_pkg::ST_IDAT_LEN;
                    pngse_pkg::ST_IDAT_LEN:  n_step = pngse_pkg::ST_IDAT_TYPE;
                    pngse_pkg::ST_IDAT_TYPE: n_step = pngse_pkg::ST_ZHDR;
                    pngse_pkg::ST_ZHDR: begin
                        n_step = pngse_pkg::ST_RAW;
                        n_sel = !i_head.filter;
                    end
                    pngse_pkg::ST_BLK:       n_step = pngse_pkg::ST_RAW;
                    pngse_pkg::ST_RAW: begin
                        if (!sel) begin
                            n_step = pngse_pkg::ST_RAW;
                            n_sel = 1'b1;
                        end else if (i_head.last) begin
                            n_step = pngse_pkg::ST_ADLER;
                        end else begin
                            n_step = pngse_pkg::ST_IDLE;
                        end
                    end
                    pngse_pkg::ST_ADLER:     n_step = pngse_pkg::ST_IDAT_CRC;
                    pngse_pkg::ST_IDAT_CRC:  n_step = pngse_pkg::ST_IEND_LEN;
                    pngse_pkg::ST_IEND_LEN:  n_step = pngse_pkg::ST_IEND_TYPE;
                    pngse_pkg::ST_IEND_TYPE: n_step = pngse_pkg::ST_IEND_CRC;
                    default:                 n_step = pngse_pkg::ST_IDLE;
                endcase
            end
        end
        done = emit && at_end && (n_step == pngse_pkg::ST_IDLE);
    end

    // byte produced by the current step
    always_comb begin
        byte_val = 8'h00;
        crc_on = 1'b0;
        crc_init = 1'b0;
        case (cur)
            pngse_pkg::ST_SIG: byte_val = pngse_pkg::sig_byte(r_idx);
            pngse_pkg::ST_IHDR_LEN: byte_val = pngse_pkg::be_byte(32'd13, r_idx);
            pngse_pkg::ST_IHDR_TYPE: begin
                byte_val = pngse_pkg::type_byte(pngse_pkg::CHUNK_IHDR, r_idx);
                crc_on = 1'b1;
                crc_init = (r_idx == 4'd0);
            end
            pngse_pkg::ST_IHDR_DATA: begin
                crc_on = 1'b1;
                if (r_idx < 4'd4) begin
                    byte_val = pngse_pkg::be_byte({17'd0, i_dims.lat_w}, r_idx);
                end else if (r_idx < 4'd8) begin
                    byte_val = pngse_pkg::be_byte({17'd0, i_dims.lat_h}, r_idx);
                end else if (r_idx == 4'd8) begin
                    byte_val = 8'd8;
                end else if (r_idx == 4'd9) begin
                    byte_val = 8'd6;
                end else begin
                    byte_val = 8'd0;
                end
            end
            pngse_pkg::ST_IHDR_CRC, pngse_pkg::ST_IDAT_CRC, pngse_pkg::ST_IEND_CRC:
                byte_val = pngse_pkg::be_byte(~r_crc, r_idx);
            pngse_pkg::ST_IDAT_LEN: byte_val = pngse_pkg::be_byte(i_dims.idat_len, r_idx);
            pngse_pkg::ST_IDAT_TYPE: begin
                byte_val = pngse_pkg::type_byte(pngse_pkg::CHUNK_IDAT, r_idx);
                crc_on = 1'b1;
                crc_init = (r_idx == 4'd0);
            end
            pngse_pkg::ST_ZHDR: begin
                byte_val = (r_idx == 4'd0) ? 8'h78 : 8'h01;
                crc_on = 1'b1;
            end
            pngse_pkg::ST_BLK: begin
                crc_on = 1'b1;
                case (r_idx)
                    4'd0: byte_val = {7'd0, ({15'd0, size} == r_raw_left)};
                    4'd1: byte_val = size[7:0];
                    4'd2: byte_val = size[15:8];
                    4'd3: byte_val = ~size[7:0];
                    default: byte_val = ~size[15:8];
                endcase
            end
            pngse_pkg::ST_RAW: begin
                byte_val = sel ? i_head.px : 8'h00;
                crc_on = 1'b1;
            end
            pngse_pkg::ST_ADLER: begin
                byte_val = pngse_pkg::be_byte({r_adler_b, r_adler_a}, r_idx);
                crc_on = 1'b1;
            end
            pngse_pkg::ST_IEND_TYPE: begin
                byte_val = pngse_pkg::type_byte(pngse_pkg::CHUNK_IEND, r_idx);
                crc_on = 1'b1;
                crc_init = (r_idx == 4'd0);
            end
            default: byte_val = 8'h00;
        endcase
        crc_next = pngse_pkg::crc_byte(crc_init ? 32'hFFFFFFFF : r_crc, byte_val);
    end

    // adler sums stay below twice the modulus, so one subtract corrects
    always_comb begin
        a_sum = {1'b0, r_adler_a} + {9'd0, byte_val};
        a_new = (a_sum >= pngse_pkg::ADLER_MOD) ? a_sum - pngse_pkg::ADLER_MOD : a_sum;
        b_sum = {1'b0, r_adler_b} + a_new;
        b_new = (b_sum >= pngse_pkg::ADLER_MOD) ? b_sum - pngse_pkg::ADLER_MOD : b_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pngse_pkg::ST_IDLE;
            r_idx <= 4'd0;
            r_sel <= 1'b0;
            r_out_valid <= 1'b0;
            r_blk_left <= 16'd0;
            r_raw_left <= 31'd0;
            r_crc <= 32'hFFFFFFFF;
            r_adler_a <= 16'd1;
            r_adler_b <= 16'd0;
        end else begin
            r_step <= n_step;
            r_idx <= n_idx;
            r_sel <= n_sel;
            if (slot_free) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                if (crc_on) begin
                    r_crc <= crc_next;
                end
                if (cur == pngse_pkg::ST_RAW) begin
                    r_adler_a <= a_new[15:0];
                    r_adler_b <= b_new[15:0];
                    r_blk_left <= r_blk_left - 16'd1;
                    r_raw_left <= r_raw_left - 31'd1;
                end
                if (cur == pngse_pkg::ST_BLK && at_end) begin
                    r_blk_left <= size;
                end
                if (cur == pngse_pkg::ST_ZHDR && at_end) begin
                    r_raw_left <= i_dims.raw;
                    r_blk_left <= 16'd0;
                    r_adler_a <= 16'd1;
                    r_adler_b <= 16'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_val;
            r_run_last <= done;
            r_file_last <= (cur == pngse_pkg::ST_IEND_CRC) && at_end;
        end
    end

    assign o_pop = done;
    assign o_hdr_done = emit && (cur == pngse_pkg::ST_ZHDR) && at_end;
    assign o_out_valid = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_run_last;
    assign o_file_last = r_file_last;

endmodule

// ===== design/png_stored_deflate_encoder.sv =====
// png encoder with stored deflate blocks: top level with config registers
// instantiates pngse_front, pngse_queue and pngse_back; uses pngse_pkg
//
// usage: write image_width (index 0) and image_height (index 1) on the config
// port while idle, then send RGBA8 component bytes in raster order on the
// input channel (i_in_valid / o_in_stall). the output channel (o_out_valid /
// i_out_stall) carries the png file byte by byte; o_run_last marks the last
// byte caused by an input beat and o_file_last the last byte of the iend crc.
// the first beat of an image opens with 43 framing bytes (signature, ihdr,
// idat length and type, zlib header), a row start adds a filter byte, a block
// start adds 5 header bytes and the last beat adds 20 trailer bytes.
// a plain pixel beat gives one byte; the back end writes one byte a cycle into
// the output register while the receiver does not stall, which sets the
// throughput. an accepted beat is registered in the queue, then in the output
// register. the idat length is worked out after image start (reciprocal
// multiply), done well before the back end reaches the idat length bytes.
// a 4-entry queue between front and back absorbs framing bursts; when it
// fills, or a new image waits for the previous header to finish, o_in_stall
// rises. when the receiver stalls, the output byte holds and the back end
// waits. reset empties the queue and sets both dimensions to 1.
module png_stored_deflate_encoder #(
    parameter int MAX_STORED_BLOCK = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_pixel_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_file_last
);

    logic [14:0] r_image_width;
    logic [14:0] r_image_height;

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              head_valid;
    logic              hdr_done;
    pngse_pkg::t_entry entry;
    pngse_pkg::t_entry head;
    pngse_pkg::t_dims  dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= 15'd1;
            r_image_height <= 15'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pngse_pkg::REG_WIDTH:  r_image_width <= i_cfg_data;
                pngse_pkg::REG_HEIGHT: r_image_height <= i_cfg_data;
                default:               r_image_width <= r_image_width;
            endcase
        end
    end

    pngse_front #(
        .MAX_STORED_BLOCK(MAX_STORED_BLOCK)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_image_width (r_image_width),
        .i_image_height(r_image_height),
        .i_in_valid    (i_in_valid),
        .i_pixel_byte  (i_pixel_byte),
        .i_queue_full  (queue_full),
        .i_hdr_done    (hdr_done),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_entry       (entry),
        .o_dims        (dims)
    );

    pngse_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(entry),
        .i_pop  (pop),
        .o_full (queue_full),
        .o_valid(head_valid),
        .o_head (head)
    );

    pngse_back #(
        .MAX_STORED_BLOCK(MAX_STORED_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head),
        .i_dims      (dims),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_hdr_done  (hdr_done),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_file_last (o_file_last)
    );

endmodule
